// ===== hdl/nucleotide_range_min_query_assert.svh =====
// Assertion macros shared by the nucleotide range query RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef NUCLEOTIDE_RANGE_MIN_QUERY_ASSERT_SVH
`define NUCLEOTIDE_RANGE_MIN_QUERY_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define NRMQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// Consequent must hold in the same cycle as the antecedent.
`define NRMQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define NRMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define NRMQ_ASSERT_ALWAYS(label, clk, rst, cond)
`define NRMQ_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define NRMQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/nrmq_pkg.sv =====
// Types and constants for the nucleotide range minimum query block.
// No dependencies; used by the top level by scoped names.
package nrmq_pkg;

   // Operation codes of an input item.
   localparam logic [1:0] OP_APPEND  = 2'd0;
   localparam logic [1:0] OP_QUERY   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // Field widths fixed by the item format.
   localparam int NUM_SYMS  = 4;
   localparam int POS_W     = 10;
   localparam int QPOS_W    = POS_W + 1;
   localparam int IMPACT_W  = 3;

   // Impact value reported with an error.
   localparam logic [IMPACT_W-1:0] IMPACT_NONE = '0;

   typedef struct packed {
      logic [1:0]       operation;
      logic [1:0]       symbol;
      logic [POS_W-1:0] range_start;
      logic [POS_W-1:0] range_end;
   } req_type;

   typedef struct packed {
      logic [IMPACT_W-1:0] min_impact;
      logic                error;
   } rsp_type;

endpackage

// ===== hdl/nrmq_ram.sv =====
// Generic synchronous RAM: one write port, two read ports with registered data.
// No dependencies; instanced by the nucleotide range query top level.
module nrmq_ram #(
   parameter int WIDTH = 44,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port and both registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== hdl/nucleotide_range_min_query.sv =====
// Top level of the nucleotide range minimum query block.
// Depends on nrmq_pkg, nrmq_ram and nucleotide_range_min_query_assert.svh.
//
// Usage:
// - An item is taken at a rising edge with start high and busy low. Its
//   operation appends a symbol, queries an inclusive position range, or
//   restarts with an empty sequence. Operation code 3 is ignored.
// - Appends store the four running symbol counts as one prefix entry per
//   position in a dual-read RAM. A query reads the entries at end+1 and at
//   start in the same cycle and reports the impact of the first symbol whose
//   count differs between them.
// - A query, or an append to a full sequence, gives one item on rsp_item
//   with rsp_strobe high for one cycle, through the read stage register
//   and then the output register. Other appends and restarts give no item.
// - Throughput is one item per cycle: the RAM write and both RAM reads of
//   an item happen at the edge that takes it, so busy stays low.
// - Reset empties the sequence and clears the running counts. Entry zero
//   reads as zero by address decode, and no entry beyond the length is read,
//   so the RAM needs no clearing pass.
// - The receiver cannot stall; each result is valid for exactly one cycle.
`include "nucleotide_range_min_query_assert.svh"

module nucleotide_range_min_query #(
   parameter int MAX_LEN = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nrmq_pkg::req_type req_item,
   output logic             rsp_strobe,
   output nrmq_pkg::rsp_type rsp_item
);

   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int CNT_W   = LEN_W;
   localparam int DEPTH   = MAX_LEN + 1;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ENTRY_W = nrmq_pkg::NUM_SYMS * CNT_W;
   localparam int CMP_W   = (LEN_W > nrmq_pkg::QPOS_W) ? LEN_W : nrmq_pkg::QPOS_W;

   // Sequence state.
   logic [LEN_W-1:0]   seq_length_ff, seq_length_in;
   logic [ENTRY_W-1:0] counts_ff, counts_in;

   // Read stage: a result is pending while the RAM data comes back.
   logic s1_valid_ff, s1_valid_in;
   logic s1_error_ff, s1_error_in;
   logic s1_zero_ff, s1_zero_in;

   // Output register.
   logic               rsp_strobe_ff, rsp_strobe_in;
   nrmq_pkg::rsp_type  rsp_item_ff, rsp_item_in;

   // RAM ports.
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr_hi, rd_addr_lo;
   logic [ENTRY_W-1:0] rd_data_hi, rd_data_lo;

   logic                     accept;
   logic                     full;
   logic                     query_bad;
   logic [nrmq_pkg::QPOS_W-1:0] end_plus;
   logic [CMP_W-1:0]         first_ext, last_ext, len_ext;

   assign accept = start && !busy;
   assign busy   = 1'b0;
   assign full   = (seq_length_ff == LEN_W'(MAX_LEN));

   // Query bounds: start must not pass end, and end must lie in the sequence.
   assign first_ext = CMP_W'(req_item.range_start);
   assign last_ext  = CMP_W'(req_item.range_end);
   assign len_ext   = CMP_W'(seq_length_ff);
   assign query_bad = (first_ext > last_ext) || (last_ext >= len_ext);
   assign end_plus  = nrmq_pkg::QPOS_W'(req_item.range_end) + nrmq_pkg::QPOS_W'(1);

   // RAM addressing: appends write the entry for the new length.
   assign wr_addr    = ADDR_W'(seq_length_ff + LEN_W'(1));
   assign rd_addr_hi = ADDR_W'(end_plus);
   assign rd_addr_lo = ADDR_W'(req_item.range_start);

   // Item decode: update counts and length, launch reads and results.
   always_comb begin
      seq_length_in = seq_length_ff;
      counts_in     = counts_ff;
      wr_en         = 1'b0;
      s1_valid_in   = 1'b0;
      s1_error_in   = 1'b0;
      s1_zero_in    = (req_item.range_start == '0);
      if (accept) begin
         unique case (req_item.operation)
            nrmq_pkg::OP_APPEND: begin
               if (full) begin
                  s1_valid_in = 1'b1;
                  s1_error_in = 1'b1;
               end else begin
                  counts_in[req_item.symbol*CNT_W +: CNT_W] =
                     counts_ff[req_item.symbol*CNT_W +: CNT_W] + CNT_W'(1);
                  seq_length_in = seq_length_ff + LEN_W'(1);
                  wr_en         = 1'b1;
               end
            end
            nrmq_pkg::OP_QUERY: begin
               s1_valid_in = 1'b1;
               s1_error_in = query_bad;
            end
            nrmq_pkg::OP_RESTART: begin
               seq_length_in = '0;
               counts_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Prefix entry store.
   nrmq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_prefix_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (counts_in),
      .rd_addr_a (rd_addr_hi),
      .rd_data_a (rd_data_hi),
      .rd_addr_b (rd_addr_lo),
      .rd_data_b (rd_data_lo)
   );

   // Result: the first symbol whose count changes across the range.
   always_comb begin
      logic [ENTRY_W-1:0] lo_entry;
      logic               found;
      lo_entry                 = s1_zero_ff ? '0 : rd_data_lo;
      found                    = 1'b0;
      rsp_strobe_in            = s1_valid_ff;
      rsp_item_in.min_impact   = nrmq_pkg::IMPACT_NONE;
      rsp_item_in.error        = 1'b1;
      if (!s1_error_ff) begin
         for (int k = 0; k < nrmq_pkg::NUM_SYMS; k++) begin
            if (!found &&
                (rd_data_hi[k*CNT_W +: CNT_W] != lo_entry[k*CNT_W +: CNT_W])) begin
               found                  = 1'b1;
               rsp_item_in.min_impact = nrmq_pkg::IMPACT_W'(k + 1);
               rsp_item_in.error      = 1'b0;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_length_ff <= '0;
         counts_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         seq_length_ff <= seq_length_in;
         counts_ff     <= counts_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_error_ff <= s1_error_in;
      s1_zero_ff  <= s1_zero_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // Checks on length bound, overflow reporting, pending results, restart and result coding.
   `NRMQ_ASSERT_ALWAYS(a_len_bound, clock, reset, seq_length_ff <= LEN_W'(MAX_LEN))
   `NRMQ_ASSERT_NEXT(a_overflow_err, clock, reset,
      accept && req_item.operation == nrmq_pkg::OP_APPEND && full,
      s1_valid_ff && s1_error_ff)
   `NRMQ_ASSERT_NEXT(a_pending_out, clock, reset, s1_valid_ff, rsp_strobe)
   `NRMQ_ASSERT_NEXT(a_restart_empty, clock, reset,
      accept && req_item.operation == nrmq_pkg::OP_RESTART,
      seq_length_ff == '0 && counts_ff == '0)
   `NRMQ_ASSERT_IMPLIES(a_err_coding, clock, reset, rsp_strobe,
      rsp_item.error == (rsp_item.min_impact == nrmq_pkg::IMPACT_NONE))

endmodule
